/* sv/psc_pkg.sv */
`default_nettype none

package psc_pkg;

  // Instruction class codes; codes six and seven decode like a logical op.
  localparam logic [2:0] CLASS_LOAD  = 3'd2;
  localparam logic [2:0] CLASS_STORE = 3'd3;
  localparam logic [2:0] CLASS_BZ    = 3'd4;
  localparam logic [2:0] CLASS_BR    = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_FORWARDING = 1'b0;
  localparam logic CFG_PREDICTION = 1'b1;

  localparam logic [1:0] FULL_STALL = 2'd2;
  localparam logic [1:0] HIST_DEPTH = 2'd2;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int REG_BITS_DEF     = 5;
  localparam int OUT_BITS         = 32;

  typedef enum logic [1:0] {
    CAUSE_NONE       = 2'd0,
    CAUSE_DATA       = 2'd1,
    CAUSE_BRANCH     = 2'd2,
    CAUSE_MISPREDICT = 2'd3
  } cause_e;

  typedef struct packed {
    logic [1:0] stall_cycles;
    cause_e     cause;
    logic       mark;
  } decision_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] hazard_stall;
    logic [OUT_BITS-1:0] branch_stall;
    logic [OUT_BITS-1:0] mispredict_stall;
    logic [OUT_BITS-1:0] hazard_affected;
    logic [OUT_BITS-1:0] branch_affected;
    logic [OUT_BITS-1:0] mispredict_affected;
    logic [OUT_BITS-1:0] instructions;
  } totals_t;

  function automatic logic is_branch(logic [2:0] cls);
    return (cls == CLASS_BZ) || (cls == CLASS_BR);
  endfunction

  function automatic logic is_producer(logic [2:0] cls);
    return (cls != CLASS_STORE) && !is_branch(cls);
  endfunction

endpackage

`default_nettype wire

/* sv/psc_in_reg.sv */
`default_nettype none

module psc_in_reg #(
  parameter int REG_BITS = psc_pkg::REG_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic                valid_i,
  input  wire logic [2:0]          op_class_i,
  input  wire logic                immediate_form_i,
  input  wire logic [REG_BITS-1:0] first_reg_i,
  input  wire logic [REG_BITS-1:0] second_reg_i,
  input  wire logic [REG_BITS-1:0] third_reg_i,
  input  wire logic                mispredicted_i,
  output logic                     valid_o,
  output logic [2:0]               op_class_o,
  output logic                     immediate_form_o,
  output logic [REG_BITS-1:0]      first_reg_o,
  output logic [REG_BITS-1:0]      second_reg_o,
  output logic [REG_BITS-1:0]      third_reg_o,
  output logic                     mispredicted_o
);

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload only when an item actually enters.
  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      op_class_o       <= op_class_i;
      immediate_form_o <= immediate_form_i;
      first_reg_o      <= first_reg_i;
      second_reg_o     <= second_reg_i;
      third_reg_o      <= third_reg_i;
      mispredicted_o   <= mispredicted_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* sv/psc_hazard.sv */
`default_nettype none

module psc_hazard #(
  parameter int REG_BITS = psc_pkg::REG_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire logic                forwarding_enable_i,
  input  wire logic                prediction_enable_i,
  input  wire logic [2:0]          op_class_i,
  input  wire logic                immediate_form_i,
  input  wire logic [REG_BITS-1:0] first_reg_i,
  input  wire logic [REG_BITS-1:0] second_reg_i,
  input  wire logic [REG_BITS-1:0] third_reg_i,
  input  wire logic                mispredicted_i,
  output psc_pkg::decision_t       decision_o
);

  import psc_pkg::*;

  logic [2:0]          cls0_q, cls1_q;
  logic [REG_BITS-1:0] dest0_q, dest1_q;
  logic [1:0]          last_stall_q;
  logic                last_mis_q;
  logic [1:0]          seen_q;

  logic [REG_BITS-1:0] ra, rb;
  logic                hit0, hit1;
  decision_t           dec;

  // Pick the registers this instruction reads.
  always_comb begin
    unique case (op_class_i)
      CLASS_LOAD: begin
        ra = second_reg_i;
        rb = second_reg_i;
      end
      CLASS_STORE, CLASS_BR: begin
        ra = first_reg_i;
        rb = second_reg_i;
      end
      CLASS_BZ: begin
        ra = first_reg_i;
        rb = first_reg_i;
      end
      default: begin
        ra = second_reg_i;
        rb = immediate_form_i ? second_reg_i : third_reg_i;
      end
    endcase
  end

  assign hit0 = (dest0_q == ra) || (dest0_q == rb);
  assign hit1 = (dest1_q == ra) || (dest1_q == rb);

  always_comb begin
    dec.stall_cycles = 2'd0;
    dec.cause        = CAUSE_NONE;
    dec.mark         = 1'b0;
    if (seen_q != 2'd0) begin
      if (!prediction_enable_i) begin
        if (is_branch(cls0_q)) begin
          dec.stall_cycles = FULL_STALL;
          dec.cause        = CAUSE_BRANCH;
        end
      end else begin
        dec.mark = is_branch(op_class_i) && mispredicted_i;
        if (last_mis_q) begin
          dec.stall_cycles = FULL_STALL;
          dec.cause        = CAUSE_MISPREDICT;
        end
      end
      // A branch-side stall already set wins over any data hazard.
      if (dec.stall_cycles == 2'd0) begin
        if (!forwarding_enable_i) begin
          if (is_producer(cls0_q) && hit0) begin
            dec.stall_cycles = FULL_STALL;
            dec.cause        = CAUSE_DATA;
          end else if ((seen_q == HIST_DEPTH) && is_producer(cls1_q) && hit1 &&
                       (last_stall_q == 2'd0)) begin
            dec.stall_cycles = FULL_STALL - 2'd1;
            dec.cause        = CAUSE_DATA;
          end
        end else if ((cls0_q == CLASS_LOAD) && hit0) begin
          dec.stall_cycles = FULL_STALL - 2'd1;
          dec.cause        = CAUSE_DATA;
        end
      end
    end
  end

  // Shift the history as each item retires into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls0_q       <= '0;
      cls1_q       <= '0;
      dest0_q      <= '0;
      dest1_q      <= '0;
      last_stall_q <= '0;
      last_mis_q   <= 1'b0;
      seen_q       <= '0;
    end else if (advance_i) begin
      cls1_q       <= cls0_q;
      dest1_q      <= dest0_q;
      cls0_q       <= op_class_i;
      dest0_q      <= first_reg_i;
      last_stall_q <= dec.stall_cycles;
      last_mis_q   <= dec.mark;
      if (seen_q != HIST_DEPTH) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

  assign decision_o = dec;

endmodule

`default_nettype wire

/* sv/psc_sat_counter.sv */
`default_nettype none

module psc_sat_counter #(
  parameter int W = psc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [1:0]   inc_i,
  output logic [W-1:0]      count_o
);

  logic [W-1:0] count_q, count_d;
  logic [W:0]   sum;

  assign sum = {1'b0, count_q} + {{(W - 1){1'b0}}, inc_i};

  // Stick at all ones once the sum carries out.
  assign count_d = sum[W] ? {W{1'b1}} : sum[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

/* sv/psc_counters.sv */
`default_nettype none

module psc_counters #(
  parameter int COUNTER_BITS = psc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire psc_pkg::decision_t decision_i,
  output psc_pkg::totals_t        totals_o
);

  import psc_pkg::*;

  localparam int NUM_CNT = 7;

  logic [NUM_CNT-1:0]      en;
  logic [1:0]              inc [NUM_CNT];
  logic [COUNTER_BITS-1:0] cnt [NUM_CNT];
  logic [OUT_BITS-1:0]     low [NUM_CNT];

  // Order: stall sums per cause, affected counts per cause, instructions.
  assign en[0] = advance_i && (decision_i.cause == CAUSE_DATA);
  assign en[1] = advance_i && (decision_i.cause == CAUSE_BRANCH);
  assign en[2] = advance_i && (decision_i.cause == CAUSE_MISPREDICT);
  assign en[3] = en[0];
  assign en[4] = en[1];
  assign en[5] = en[2];
  assign en[6] = advance_i;

  assign inc[0] = decision_i.stall_cycles;
  assign inc[1] = decision_i.stall_cycles;
  assign inc[2] = decision_i.stall_cycles;
  assign inc[3] = 2'd1;
  assign inc[4] = 2'd1;
  assign inc[5] = 2'd1;
  assign inc[6] = 2'd1;

  for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
    logic [COUNTER_BITS+OUT_BITS-1:0] ext;

    psc_sat_counter #(
      .W (COUNTER_BITS)
    ) u_cnt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .inc_i   (inc[g]),
      .count_o (cnt[g])
    );

    // Show the low bits, zero-extended for narrow counters.
    assign ext    = {{OUT_BITS{1'b0}}, cnt[g]};
    assign low[g] = ext[OUT_BITS-1:0];
  end

  assign totals_o.hazard_stall        = low[0];
  assign totals_o.branch_stall        = low[1];
  assign totals_o.mispredict_stall    = low[2];
  assign totals_o.hazard_affected     = low[3];
  assign totals_o.branch_affected     = low[4];
  assign totals_o.mispredict_affected = low[5];
  assign totals_o.instructions        = low[6];

endmodule

`default_nettype wire

/* sv/pipeline_stall_calculator.sv */
// Hazard detection unit for a five-stage in-order pipeline.
//
// Input channel (in_valid_i / in_ready_o) carries one decoded instruction
// per item; output channel (out_valid_o / out_ready_i) returns its stall
// cycles, cause and misprediction mark, plus the running saturating totals
// taken after that instruction.
// Path: an accepted item lands in the input register, and its result is
// then loaded into the result register once that register is free or
// draining, where the receiver can take it.
// Throughput: one item per cycle while the receiver does not stall. The stall decision is a single pass of
// register compares against the two-deep history, and the history and
// counters update in the same edge that loads the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then in_ready_o drops until the result drains.
// Reset clears the history, the counters, both valid flags and the two
// configuration bits (forwarding and prediction off).
// Configuration: write cfg_data_i into the register picked by cfg_index_i
// while cfg_we_i is high; write only while no item is in flight.

`default_nettype none

module pipeline_stall_calculator #(
  parameter int COUNTER_BITS = psc_pkg::COUNTER_BITS_DEF,
  parameter int REG_BITS     = psc_pkg::REG_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_index_i,
  input  wire logic                     cfg_data_i,
  // Instruction items
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [2:0]               op_class_i,
  input  wire logic                     immediate_form_i,
  input  wire logic [REG_BITS-1:0]      first_reg_i,
  input  wire logic [REG_BITS-1:0]      second_reg_i,
  input  wire logic [REG_BITS-1:0]      third_reg_i,
  input  wire logic                     mispredicted_i,
  // Result items
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    stall_cycles_o,
  output logic [1:0]                    stall_cause_o,
  output logic                          marked_mispredict_o,
  output logic [psc_pkg::OUT_BITS-1:0]  hazard_stall_total_o,
  output logic [psc_pkg::OUT_BITS-1:0]  branch_stall_total_o,
  output logic [psc_pkg::OUT_BITS-1:0]  mispredict_stall_total_o,
  output logic [psc_pkg::OUT_BITS-1:0]  hazard_affected_o,
  output logic [psc_pkg::OUT_BITS-1:0]  branch_affected_o,
  output logic [psc_pkg::OUT_BITS-1:0]  mispredict_affected_o,
  output logic [psc_pkg::OUT_BITS-1:0]  instruction_count_o
);

  import psc_pkg::*;

  logic                fwd_q, pred_q;
  logic                item_valid;
  logic                advance;
  logic                out_valid_q;
  logic [2:0]          item_class;
  logic                item_imm;
  logic [REG_BITS-1:0] item_f1, item_f2, item_f3;
  logic                item_misp;
  decision_t           decision;
  decision_t           result_q;
  totals_t             totals;

  // Configuration bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      pred_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FORWARDING: fwd_q  <= cfg_data_i;
        CFG_PREDICTION: pred_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result register is free or draining.
  assign advance    = item_valid && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid || advance;

  psc_in_reg #(
    .REG_BITS (REG_BITS)
  ) u_in_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (in_ready_o),
    .valid_i          (in_valid_i),
    .op_class_i       (op_class_i),
    .immediate_form_i (immediate_form_i),
    .first_reg_i      (first_reg_i),
    .second_reg_i     (second_reg_i),
    .third_reg_i      (third_reg_i),
    .mispredicted_i   (mispredicted_i),
    .valid_o          (item_valid),
    .op_class_o       (item_class),
    .immediate_form_o (item_imm),
    .first_reg_o      (item_f1),
    .second_reg_o     (item_f2),
    .third_reg_o      (item_f3),
    .mispredicted_o   (item_misp)
  );

  psc_hazard #(
    .REG_BITS (REG_BITS)
  ) u_hazard (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .advance_i           (advance),
    .forwarding_enable_i (fwd_q),
    .prediction_enable_i (pred_q),
    .op_class_i          (item_class),
    .immediate_form_i    (item_imm),
    .first_reg_i         (item_f1),
    .second_reg_i        (item_f2),
    .third_reg_i         (item_f3),
    .mispredicted_i      (item_misp),
    .decision_o          (decision)
  );

  // Counters move only when the result register loads, so their outputs
  // always match the result being shown.
  psc_counters #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .decision_i (decision),
    .totals_o   (totals)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold until taken.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= decision;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign stall_cycles_o           = result_q.stall_cycles;
  assign stall_cause_o            = result_q.cause;
  assign marked_mispredict_o      = result_q.mark;
  assign hazard_stall_total_o     = totals.hazard_stall;
  assign branch_stall_total_o     = totals.branch_stall;
  assign mispredict_stall_total_o = totals.mispredict_stall;
  assign hazard_affected_o        = totals.hazard_affected;
  assign branch_affected_o        = totals.branch_affected;
  assign mispredict_affected_o    = totals.mispredict_affected;
  assign instruction_count_o      = totals.instructions;

endmodule

`default_nettype wire

/* sv/psc_checker.sv */
`default_nettype none

module psc_assert (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [1:0] stall_cycles_i,
  input  wire logic [1:0] stall_cause_i,
  input  wire logic       marked_mispredict_i
);

  import psc_pkg::*;

  // Result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Stall count and cause agree on whether anything stalled.
  a_cause_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((stall_cycles_i == 2'd0) == (stall_cause_i == CAUSE_NONE)))
    else $error("stall cycles and cause disagree");

  // Branch-side stalls always take the full penalty.
  a_branch_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((stall_cause_i == CAUSE_BRANCH) || (stall_cause_i == CAUSE_MISPREDICT))
    |-> (stall_cycles_i == FULL_STALL))
    else $error("branch stall not at full penalty");

  // Plain branch stalls only occur with prediction off, where nothing is marked.
  a_mark_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (stall_cause_i == CAUSE_BRANCH) |-> !marked_mispredict_i)
    else $error("mispredict mark with prediction off");

endmodule

bind pipeline_stall_calculator psc_assert u_psc_assert (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .stall_cycles_i      (stall_cycles_o),
  .stall_cause_i       (stall_cause_o),
  .marked_mispredict_i (marked_mispredict_o)
);

`default_nettype wire
